// ===== rtl/dq_pkg.sv =====
package dq_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [2:0] OP_PUSH_R = 3'd0;
    localparam logic [2:0] OP_POP_L  = 3'd1;
    localparam logic [2:0] OP_POP_R  = 3'd2;
    localparam logic [2:0] OP_PEEK_L = 3'd3;
    localparam logic [2:0] OP_PEEK_R = 3'd4;

    // Status codes carried on the output tuser.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_UNDER = 2'd1;
    localparam logic [1:0] STATUS_OVER  = 2'd2;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed widths of the word fields.
    localparam int OP_W        = 3;
    localparam int VALUE_OUT_W = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    // Controls broadcast from the top level to every cell. At most one is set.
    typedef struct packed {
        logic push;
        logic pop_left;
        logic pop_right;
    } dq_ctrl_t;

endpackage

// ===== rtl/dq_cell.sv =====
module dq_cell #(
    parameter int VALUE_WIDTH = dq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dq_pkg::dq_ctrl_t       ctrl,
    input  logic [VALUE_WIDTH-1:0] push_value,
    input  logic                   prev_valid,
    input  logic                   next_valid,
    input  logic [VALUE_WIDTH-1:0] next_data,
    output logic                   valid,
    output logic [VALUE_WIDTH-1:0] data,
    output logic [VALUE_WIDTH-1:0] tap
);
    import dq_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.pop_left) begin
            // Every entry moves one place toward the left end.
            valid_next = next_valid;
            data_next  = next_data;
        end else if (ctrl.pop_right) begin
            // The rightmost occupied cell lets go of its entry.
            valid_next = valid_reg & next_valid;
        end else if (ctrl.push && !valid_reg && prev_valid) begin
            // The first free cell takes the new entry.
            valid_next = 1'b1;
            data_next  = push_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign tap   = (valid_reg && !next_valid) ? data_reg : '0;

endmodule

// ===== rtl/double_ended_queue_top.sv =====
// Result: a result word appears on the m_ side in the cycle after its input word is accepted.
// Throughput: one word per cycle; the output register lets a new word in while the
// previous result is taken in the same cycle, so only a stalled m_ side slows it down.
// Reset: aresetn is synchronous and active low; it empties the queue and drops any
// pending result. Stored entry data is not cleared.
module double_ended_queue_top #(
    parameter int DEPTH       = dq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = dq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dq_pkg::S_TDATA_W-1:0]   s_tdata,  // [31:0] push_value
    input  logic [dq_pkg::OP_W-1:0]        s_tuser,  // [2:0] operation
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dq_pkg::M_TDATA_W-1:0]   m_tdata,  // [31:0] read_value, [32] is_empty,
                                                     // [37:33] entry_count, [39:38] zero
    output logic [dq_pkg::STATUS_W-1:0]    m_tuser   // [1:0] status
);
    import dq_pkg::*;

    // The queue lives in a row of DEPTH cells. Cell 0 always holds the left end and
    // the occupied cells form an unbroken run from cell 0. A push fills the first free
    // cell, a left pop shifts the whole row one place left, and a right pop clears the
    // last occupied cell. Each cell offers its entry on a tap when it is the rightmost
    // occupied cell, so the right end is the OR of all taps.
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   out_valid_reg;
    logic [M_TDATA_W-1:0]   out_data_reg;
    logic [M_TDATA_W-1:0]   out_data_next;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [STATUS_W-1:0]    out_status_next;

    logic [DEPTH-1:0]       cell_valid;
    logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_tap  [DEPTH];
    logic [VALUE_WIDTH-1:0] push_value;
    logic [VALUE_WIDTH-1:0] right_value;
    logic [VALUE_WIDTH-1:0] read_value;
    logic [VALUE_OUT_W-1:0] read_value_out;
    logic [COUNT_OUT_W-1:0] count_out;
    logic [OP_W-1:0]        op;
    logic                   accept;
    logic                   empty;
    logic                   full;
    dq_ctrl_t               ctrl;

    // A new word is taken whenever the output register is free or being emptied.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = s_tuser;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));

    // The push value is kept to VALUE_WIDTH bits.
    generate
        if (VALUE_WIDTH <= S_TDATA_W) begin : g_push_narrow
            assign push_value = s_tdata[VALUE_WIDTH-1:0];
        end else begin : g_push_wide
            assign push_value = {{(VALUE_WIDTH - S_TDATA_W){1'b0}}, s_tdata};
        end
    endgenerate

    // Controls for the cell row; each is set only when the operation is legal.
    always_comb begin
        ctrl.push      = accept && (op == OP_PUSH_R) && !full;
        ctrl.pop_left  = accept && (op == OP_POP_L)  && !empty;
        ctrl.pop_right = accept && (op == OP_POP_R)  && !empty;
    end

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            logic                   prev_v;
            logic                   next_v;
            logic [VALUE_WIDTH-1:0] next_d;
            if (i == 0) begin : g_first
                assign prev_v = 1'b1;
            end else begin : g_inner_prev
                assign prev_v = cell_valid[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign next_v = 1'b0;
                assign next_d = '0;
            end else begin : g_inner_next
                assign next_v = cell_valid[i+1];
                assign next_d = cell_data[i+1];
            end
            dq_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .push_value (push_value),
                .prev_valid (prev_v),
                .next_valid (next_v),
                .next_data  (next_d),
                .valid      (cell_valid[i]),
                .data       (cell_data[i]),
                .tap        (cell_tap[i])
            );
        end
    endgenerate

    // At most one tap is nonzero, so the OR picks the right end.
    always_comb begin
        right_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            right_value = right_value | cell_tap[i];
        end
    end

    // Operation decode: the value read, the status and the new count.
    always_comb begin
        read_value      = '0;
        out_status_next = STATUS_OK;
        count_next      = count_reg;
        case (op)
            OP_PUSH_R: begin
                if (full) begin
                    out_status_next = STATUS_OVER;
                end else begin
                    count_next = count_reg + CW'(1);
                end
            end
            OP_POP_L, OP_PEEK_L: begin
                if (empty) begin
                    out_status_next = STATUS_UNDER;
                end else begin
                    read_value = cell_data[0];
                    if (op == OP_POP_L) begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            OP_POP_R, OP_PEEK_R: begin
                if (empty) begin
                    out_status_next = STATUS_UNDER;
                end else begin
                    read_value = right_value;
                    if (op == OP_POP_R) begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default: begin
                // Unused codes leave the queue alone and report its state.
            end
        endcase
    end

    // Fit the value and the count into their fixed word fields.
    generate
        if (VALUE_WIDTH >= VALUE_OUT_W) begin : g_rd_narrow
            assign read_value_out = read_value[VALUE_OUT_W-1:0];
        end else begin : g_rd_wide
            assign read_value_out = {{(VALUE_OUT_W - VALUE_WIDTH){1'b0}}, read_value};
        end
        if (CW >= COUNT_OUT_W) begin : g_cnt_narrow
            assign count_out = count_next[COUNT_OUT_W-1:0];
        end else begin : g_cnt_wide
            assign count_out = {{(COUNT_OUT_W - CW){1'b0}}, count_next};
        end
    endgenerate

    assign out_data_next = {{(M_TDATA_W - VALUE_OUT_W - 1 - COUNT_OUT_W){1'b0}},
                            count_out, (count_next == '0), read_value_out};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ===== rtl/dq_checker.sv =====
module dq_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [dq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [dq_pkg::STATUS_W-1:0]  m_tuser
);
    import dq_pkg::*;

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // A stalled result holds its word.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The empty flag agrees with the reported count.
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[32] == (m_tdata[37:33] == 5'd0)))
        else $error("empty flag disagrees with count");

    // An underflow leaves an empty queue and reads zero.
    a_under: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_UNDER) |-> m_tdata[32] && (m_tdata[31:0] == 32'd0))
        else $error("underflow result malformed");

    // An overflow can only happen on a queue that holds entries.
    a_over: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_OVER) |-> !m_tdata[32] && (m_tdata[31:0] == 32'd0))
        else $error("overflow result malformed");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dq_pkg::*;

    // Queue geometry as built into the block under test.
    localparam int DQ_DEPTH = DEPTH_DEF;

    // Operation codes that the block ignores.
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    // Counted words of the random part (ignored codes excluded).
    localparam int RANDOM_WORDS = 600;

    // The run is stopped here.
    localparam int CYCLE_LIMIT = 200000;

    // Cycles to wait after the last result for any stray word.
    localparam int DRAIN_CYCLES = 8;

    // Fields of one result word, in the order that they are compared.
    typedef struct packed {
        logic [VALUE_OUT_W-1:0] read_value;
        logic                   is_empty;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic [STATUS_W-1:0]    status;
    } dq_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = OP_PUSH_R;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // Shadow copy of the deque contents, kept in step with accepted words.
    logic [VALUE_OUT_W-1:0] shadow_store [DQ_DEPTH];
    logic [3:0]             shadow_head  = '0;
    logic [COUNT_OUT_W-1:0] shadow_count = '0;

    // Results owed by the block, oldest first.
    dq_result_t owed_results [$];

    int failures       = 0;
    int cycle_count    = 0;
    int results_taken  = 0;
    int stall_drawn_at = 0;
    int stall_left     = 0;

    // Idle controls, changed by the tests to mix stretches of gaps and of full rate.
    bit sender_idles    = 1'b1;
    bit receiver_stalls = 1'b1;

    double_ended_queue_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Applies one operation to the shadow deque and returns the result it owes.
    // Only slots inside the occupied range are read, and each of those was pushed.
    function automatic dq_result_t apply_deque_op(input logic [OP_W-1:0] op,
                                                  input logic [S_TDATA_W-1:0] value);
        dq_result_t r;
        logic [3:0] slot;
        r.read_value = '0;
        r.status     = STATUS_OK;
        case (op)
            OP_PUSH_R: begin
                if (shadow_count == COUNT_OUT_W'(DQ_DEPTH)) begin
                    r.status = STATUS_OVER;
                end else begin
                    slot = shadow_head + shadow_count[3:0];
                    shadow_store[slot] = value;
                    shadow_count = shadow_count + COUNT_OUT_W'(1);
                end
            end
            OP_POP_L, OP_POP_R, OP_PEEK_L, OP_PEEK_R: begin
                if (shadow_count == '0) begin
                    r.status = STATUS_UNDER;
                end else begin
                    // The right end is one slot before head plus count, modulo the depth.
                    if (op == OP_POP_L || op == OP_PEEK_L) begin
                        slot = shadow_head;
                    end else begin
                        slot = shadow_head + shadow_count[3:0] - 4'd1;
                    end
                    r.read_value = shadow_store[slot];
                    if (op == OP_POP_L) begin
                        shadow_head  = shadow_head + 4'd1;
                        shadow_count = shadow_count - COUNT_OUT_W'(1);
                    end else if (op == OP_POP_R) begin
                        shadow_count = shadow_count - COUNT_OUT_W'(1);
                    end
                end
            end
            default: begin
                // Spare codes leave the state alone and still report it.
            end
        endcase
        r.is_empty    = (shadow_count == '0);
        r.entry_count = shadow_count;
        return r;
    endfunction

    // Both channels are sampled here at the rising edge. A result is checked before
    // the word accepted at the same edge is predicted; as every result is registered,
    // the two never belong together.
    always @(posedge aclk) begin : word_monitor
        dq_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_taken++;
                if (owed_results.size() == 0) begin
                    $display("%0t: result word with none expected, got tdata %h tuser %h",
                             $time, m_tdata, m_tuser);
                    failures++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_tdata[31:0] !== want.read_value) begin
                        $display("%0t: read_value expected %h, got %h",
                                 $time, want.read_value, m_tdata[31:0]);
                        failures++;
                    end
                    if (m_tdata[32] !== want.is_empty) begin
                        $display("%0t: is_empty expected %b, got %b",
                                 $time, want.is_empty, m_tdata[32]);
                        failures++;
                    end
                    if (m_tdata[37:33] !== want.entry_count) begin
                        $display("%0t: entry_count expected %0d, got %0d",
                                 $time, want.entry_count, m_tdata[37:33]);
                        failures++;
                    end
                    if (m_tuser !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_tuser);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                owed_results.insert(owed_results.size(), apply_deque_op(s_tuser, s_tdata));
            end
        end
    end

    // The receiver draws a fresh stall after every word it takes. Ready changes
    // only at the falling edge.
    always @(negedge aclk) begin
        if (results_taken != stall_drawn_at) begin
            stall_drawn_at = results_taken;
            stall_left     = receiver_stalls ? $urandom_range(0, 15) : 0;
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one word after a random gap and returns at the falling edge after it
    // was accepted. Valid stays high across back-to-back words, so it is never
    // lowered and raised in the same step.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [S_TDATA_W-1:0] value);
        int gap;
        gap = sender_idles ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Pops and peeks on the empty queue after reset must all underflow.
    task automatic test_empty_underflow;
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        send_word(OP_POP_L,  $urandom);
        send_word(OP_POP_R,  $urandom);
        send_word(OP_PEEK_L, $urandom);
        send_word(OP_PEEK_R, $urandom);
    endtask

    // Fills the queue with the value extremes first, then pushes once more into
    // the full queue, which must be dropped as an overflow.
    task automatic test_fill_to_overflow;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        send_word(OP_PUSH_R, 32'h0000_0000);
        send_word(OP_PUSH_R, 32'hFFFF_FFFF);
        repeat (DQ_DEPTH - 2) send_word(OP_PUSH_R, $urandom);
        send_word(OP_PUSH_R, 32'hFFFF_FFFF);
    endtask

    // Reads both ends of the full queue, then tries a spare code on the queue that is left.
    task automatic test_full_ends;
        sender_idles    = 1'b0;
        receiver_stalls = 1'b1;
        send_word(OP_PEEK_L, $urandom);
        send_word(OP_POP_R,  $urandom);
        send_word(OP_SPARE_FIRST, $urandom);
    endtask

    // Long random traffic in chunks. Each chunk leans toward filling, draining or
    // neither, so the queue sweeps between empty and full and the pointers wrap.
    // About one word in twenty carries a spare code as noise.
    task automatic test_random_traffic;
        int              counted;
        int              push_pct;
        logic [OP_W-1:0] op;
        logic [31:0]     value;
        counted = 0;
        while (counted < RANDOM_WORDS) begin
            case ($urandom_range(0, 2))
                0:       push_pct = 75;
                1:       push_pct = 25;
                default: push_pct = 40;
            endcase
            sender_idles    = 1'($urandom_range(0, 1));
            receiver_stalls = 1'($urandom_range(0, 1));
            repeat (40) begin
                if ($urandom_range(0, 19) == 0) begin
                    op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                end else if ($urandom_range(0, 99) < push_pct) begin
                    op = OP_PUSH_R;
                end else begin
                    op = OP_W'($urandom_range(OP_POP_L, OP_PEEK_R));
                end
                case ($urandom_range(0, 7))
                    0:       value = 32'h0000_0000;
                    1:       value = 32'hFFFF_FFFF;
                    default: value = $urandom;
                endcase
                send_word(op, value);
                if (op <= OP_PEEK_R) begin
                    counted++;
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_underflow();
        test_fill_to_overflow();
        test_full_ends();
        test_random_traffic();

        // Stimulus done: let the block return every owed word, then watch a few
        // more cycles for anything extra.
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/double_ended_queue_top.sv
rtl/dq_checker.sv
test/tb_top.sv
